[rtl/dhcp_pkg.sv]
// Package for the DHCP client sequencer: state encoding, message codes,
// register indexes and reset values, and the structs passed between modules.
// No dependencies.
package dhcp_pkg;

  // Client states; code 7 is unused
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_DISC_SENT  = 3'd1,
    ST_WAIT_OFFER = 3'd2,
    ST_REQ_SENT   = 3'd3,
    ST_WAIT_ACK   = 3'd4,
    ST_BOUND      = 3'd5,
    ST_ERROR      = 3'd6
  } state_e;

  // Item opcodes
  localparam logic OP_POLL  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Message type option values
  localparam logic [7:0] MSG_OFFER = 8'd2;
  localparam logic [7:0] MSG_ACK   = 8'd5;
  localparam logic [7:0] MSG_NAK   = 8'd6;

  // Lease assumed when an ACK carries no lease option
  localparam logic [31:0] DEFAULT_LEASE = 32'd86400;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_XID       = 3'd0;
  localparam logic [2:0] CFG_TMO_BASE  = 3'd1;
  localparam logic [2:0] CFG_TMO_CAP   = 3'd2;
  localparam logic [2:0] CFG_RETRY_LIM = 3'd3;
  localparam logic [2:0] CFG_ERR_DELAY = 3'd4;
  localparam logic [2:0] CFG_TPS       = 3'd5;

  // Register reset values
  localparam logic [31:0] RST_XID       = 32'h1234_5678;
  localparam logic [15:0] RST_TMO_BASE  = 16'd500;
  localparam logic [15:0] RST_TMO_CAP   = 16'd6400;
  localparam logic [2:0]  RST_RETRY_LIM = 3'd3;
  localparam logic [15:0] RST_ERR_DELAY = 16'd2000;
  localparam logic [9:0]  RST_TPS       = 10'd100;

  // Configuration register set
  typedef struct packed {
    logic [31:0] xid;
    logic [15:0] tmo_base;
    logic [15:0] tmo_cap;
    logic [2:0]  retry_lim;
    logic [15:0] err_delay;
    logic [9:0]  tps;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic        opcode;
    logic [63:0] now_ticks;
    logic        send_ok;
    logic        pkt_valid;
    logic [31:0] pkt_xid;
    logic [7:0]  pkt_msg_type;
    logic [31:0] pkt_your_ip;
    logic [31:0] pkt_server_id;
    logic        pkt_server_id_present;
    logic [31:0] pkt_source_ip;
    logic [31:0] pkt_lease_seconds;
    logic        pkt_lease_present;
  } item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  client_state;
    logic        send_discover;
    logic        send_request;
    logic        bound_now;
    logic [31:0] assigned_ip;
    logic [31:0] requested_ip;
    logic [31:0] server_ip;
    logic [31:0] lease_length;
    logic [63:0] renew_at;
  } res_t;

endpackage

[rtl/dhcp_cfg_regs.sv]
// Configuration register file for the DHCP client sequencer.
// Depends on dhcp_pkg for the register indexes, reset values and cfg_t.
module dhcp_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output dhcp_pkg::cfg_t     cfg_o
);
  import dhcp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a write
  assign cfg_ready_o = 1'b1;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_XID:       cfg_d.xid       = cfg_data_i;
        CFG_TMO_BASE:  cfg_d.tmo_base  = cfg_data_i[15:0];
        CFG_TMO_CAP:   cfg_d.tmo_cap   = cfg_data_i[15:0];
        CFG_RETRY_LIM: cfg_d.retry_lim = cfg_data_i[2:0];
        CFG_ERR_DELAY: cfg_d.err_delay = cfg_data_i[15:0];
        CFG_TPS:       cfg_d.tps       = cfg_data_i[9:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.xid       <= RST_XID;
      cfg_q.tmo_base  <= RST_TMO_BASE;
      cfg_q.tmo_cap   <= RST_TMO_CAP;
      cfg_q.retry_lim <= RST_RETRY_LIM;
      cfg_q.err_delay <= RST_ERR_DELAY;
      cfg_q.tps       <= RST_TPS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/dhcp_seq.sv]
// Client state machine: state, retry and tick counters, lease bookkeeping,
// and the result for the item held in the input register. Depends on dhcp_pkg.
module dhcp_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  dhcp_pkg::item_t item_i,
  input  dhcp_pkg::cfg_t  cfg_i,
  output dhcp_pkg::res_t  res_o
);
  import dhcp_pkg::*;

  state_e      state_q, state_d;
  logic [2:0]  retry_q, retry_d;
  logic [15:0] tick_q, tick_d;
  logic [31:0] offered_q, offered_d;
  logic [31:0] server_q, server_d;
  logic [31:0] lease_q, lease_d;
  logic [63:0] renew_q, renew_d;
  logic        lcfg_q, lcfg_d;

  logic        disc, req, bound;
  logic        is_poll, is_start, start_ok;
  logic        match, offer_hit, ack_hit, nak_hit, renew_hit;
  logic [15:0] tick_inc;
  logic [22:0] tmo_shift;
  logic [15:0] tmo;
  logic        timed_out, can_retry, err_expired;
  logic [31:0] lease_new;
  logic [41:0] lease_ticks;
  logic [63:0] renew_new;

  // Item decode and packet filtering
  assign is_start  = item_i.opcode == OP_START;
  assign is_poll   = item_i.opcode == OP_POLL;
  assign start_ok  = (state_q == ST_IDLE) || (state_q == ST_ERROR);
  assign match     = item_i.pkt_valid && (item_i.pkt_xid == cfg_i.xid);
  assign offer_hit = match && (item_i.pkt_msg_type == MSG_OFFER);
  assign ack_hit   = match && (item_i.pkt_msg_type == MSG_ACK);
  assign nak_hit   = match && (item_i.pkt_msg_type == MSG_NAK);
  assign renew_hit = is_poll && (state_q == ST_BOUND) && lcfg_q &&
                     (renew_q != 64'd0) && (item_i.now_ticks >= renew_q);

  // Saturating tick and backed-off timeout
  assign tick_inc    = (tick_q != 16'hFFFF) ? tick_q + 16'd1 : tick_q;
  assign tmo_shift   = {7'd0, cfg_i.tmo_base} << retry_q;
  assign tmo         = (tmo_shift > {7'd0, cfg_i.tmo_cap}) ? cfg_i.tmo_cap : tmo_shift[15:0];
  assign timed_out   = tick_inc >= tmo;
  assign can_retry   = retry_q < cfg_i.retry_lim;
  assign err_expired = tick_inc >= cfg_i.err_delay;

  // Renewal point at half the lease
  assign lease_new   = item_i.pkt_lease_present ? item_i.pkt_lease_seconds : DEFAULT_LEASE;
  assign lease_ticks = {10'd0, lease_new} * {32'd0, cfg_i.tps};
  assign renew_new   = item_i.now_ticks + {23'd0, lease_ticks[41:1]};

  // Next state and counters
  always_comb begin
    state_d = state_q;
    retry_d = retry_q;
    tick_d  = tick_q;
    if (is_start) begin
      if (start_ok) begin
        state_d = item_i.send_ok ? ST_DISC_SENT : ST_ERROR;
        retry_d = '0;
        tick_d  = '0;
      end
    end else if (renew_hit) begin
      state_d = ST_IDLE;
      retry_d = '0;
      tick_d  = '0;
    end else begin
      unique case (state_q)
        ST_DISC_SENT: begin
          state_d = ST_WAIT_OFFER;
          tick_d  = '0;
        end
        ST_REQ_SENT: begin
          state_d = ST_WAIT_ACK;
          tick_d  = '0;
        end
        ST_WAIT_OFFER, ST_WAIT_ACK: begin
          if (offer_hit && state_q == ST_WAIT_OFFER) begin
            state_d = item_i.send_ok ? ST_REQ_SENT : ST_ERROR;
            retry_d = '0;
            tick_d  = '0;
          end else if ((ack_hit || nak_hit) && state_q == ST_WAIT_ACK) begin
            state_d = ack_hit ? ST_BOUND : ST_ERROR;
            retry_d = '0;
            tick_d  = '0;
          end else if (!timed_out) begin
            tick_d = tick_inc;
          end else if (can_retry && item_i.send_ok) begin
            state_d = (state_q == ST_WAIT_OFFER) ? ST_DISC_SENT : ST_REQ_SENT;
            retry_d = retry_q + 3'd1;
            tick_d  = '0;
          end else begin
            state_d = ST_ERROR;
            retry_d = '0;
            tick_d  = '0;
          end
        end
        ST_ERROR: begin
          if (err_expired) begin
            state_d = item_i.send_ok ? ST_DISC_SENT : ST_ERROR;
            retry_d = '0;
            tick_d  = '0;
          end else begin
            tick_d = tick_inc;
          end
        end
        default: state_d = state_q;
      endcase
    end
  end

  // Pulses and lease / address bookkeeping
  always_comb begin
    disc      = 1'b0;
    req       = 1'b0;
    bound     = 1'b0;
    offered_d = offered_q;
    server_d  = server_q;
    lease_d   = lease_q;
    renew_d   = renew_q;
    lcfg_d    = lcfg_q;
    if (is_start) begin
      disc = start_ok;
    end else if (renew_hit) begin
      renew_d = '0;
      lcfg_d  = 1'b0;
    end else begin
      unique case (state_q)
        ST_WAIT_OFFER: begin
          if (offer_hit) begin
            offered_d = item_i.pkt_your_ip;
            server_d  = item_i.pkt_server_id_present ? item_i.pkt_server_id
                                                     : item_i.pkt_source_ip;
            req       = 1'b1;
          end else begin
            disc = timed_out && can_retry;
          end
        end
        ST_WAIT_ACK: begin
          if (ack_hit) begin
            lease_d = lease_new;
            renew_d = renew_new;
            lcfg_d  = 1'b1;
            bound   = 1'b1;
          end else if (!nak_hit) begin
            req = timed_out && can_retry;
          end
        end
        ST_ERROR: begin
          if (err_expired) begin
            lcfg_d  = 1'b0;
            renew_d = '0;
            disc    = 1'b1;
          end
        end
        default: disc = 1'b0;
      endcase
    end
  end

  // State registers advance once per transfer into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      retry_q   <= '0;
      tick_q    <= '0;
      offered_q <= '0;
      server_q  <= '0;
      lease_q   <= '0;
      renew_q   <= '0;
      lcfg_q    <= 1'b0;
    end else if (advance_i) begin
      state_q   <= state_d;
      retry_q   <= retry_d;
      tick_q    <= tick_d;
      offered_q <= offered_d;
      server_q  <= server_d;
      lease_q   <= lease_d;
      renew_q   <= renew_d;
      lcfg_q    <= lcfg_d;
    end
  end

  // Result for this item
  always_comb begin
    res_o.client_state  = state_d;
    res_o.send_discover = disc;
    res_o.send_request  = req;
    res_o.bound_now     = bound;
    res_o.assigned_ip   = bound ? item_i.pkt_your_ip : 32'd0;
    res_o.requested_ip  = offered_d;
    res_o.server_ip     = server_d;
    res_o.lease_length  = lease_d;
    res_o.renew_at      = renew_d;
  end

endmodule

[rtl/dhcp_client_fsm_core.sv]
// Top level of the DHCP client sequencer: input register, result register
// and handshakes. Depends on dhcp_pkg, dhcp_cfg_regs and dhcp_seq.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------
//  item in  | in_valid_i / in_stall_o   | opcode_i .. pkt_lease_present_i
//  result   | out_valid_o / out_stall_i | client_state_o .. renew_at_o
//  config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item is registered on transfer and its result when it advances; one item
// is taken every cycle unless the result stalls. The state machine, the
// 32x10 lease multiply and the 64-bit renewal add sit between the input and
// result registers. Reset clears the valid flags and the sequencer state and
// loads the configuration defaults. A stalled result holds the input
// register; the input side stalls only when both registers are full.
module dhcp_client_fsm_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [63:0] now_ticks_i,
  input  logic        send_ok_i,
  input  logic        pkt_valid_i,
  input  logic [31:0] pkt_xid_i,
  input  logic [7:0]  pkt_msg_type_i,
  input  logic [31:0] pkt_your_ip_i,
  input  logic [31:0] pkt_server_id_i,
  input  logic        pkt_server_id_present_i,
  input  logic [31:0] pkt_source_ip_i,
  input  logic [31:0] pkt_lease_seconds_i,
  input  logic        pkt_lease_present_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  client_state_o,
  output logic        send_discover_o,
  output logic        send_request_o,
  output logic        bound_now_o,
  output logic [31:0] assigned_ip_o,
  output logic [31:0] requested_ip_o,
  output logic [31:0] server_ip_o,
  output logic [31:0] lease_length_o,
  output logic [63:0] renew_at_o
);
  import dhcp_pkg::*;

  cfg_t  cfg;
  item_t item_in;
  item_t item_q;
  res_t  res, res_q;
  logic  in_vld_q, in_vld_d;
  logic  out_vld_q, out_vld_d;
  logic  out_free, advance, in_xfer;

  dhcp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Gather the item fields
  always_comb begin
    item_in.opcode                = opcode_i;
    item_in.now_ticks             = now_ticks_i;
    item_in.send_ok               = send_ok_i;
    item_in.pkt_valid             = pkt_valid_i;
    item_in.pkt_xid               = pkt_xid_i;
    item_in.pkt_msg_type          = pkt_msg_type_i;
    item_in.pkt_your_ip           = pkt_your_ip_i;
    item_in.pkt_server_id         = pkt_server_id_i;
    item_in.pkt_server_id_present = pkt_server_id_present_i;
    item_in.pkt_source_ip         = pkt_source_ip_i;
    item_in.pkt_lease_seconds     = pkt_lease_seconds_i;
    item_in.pkt_lease_present     = pkt_lease_present_i;
  end

  // Pipeline flow control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_xfer || (in_vld_q && !advance);
  assign out_vld_d  = advance || (out_vld_q && out_stall_i);

  dhcp_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= item_in;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign client_state_o  = res_q.client_state;
  assign send_discover_o = res_q.send_discover;
  assign send_request_o  = res_q.send_request;
  assign bound_now_o     = res_q.bound_now;
  assign assigned_ip_o   = res_q.assigned_ip;
  assign requested_ip_o  = res_q.requested_ip;
  assign server_ip_o     = res_q.server_ip;
  assign lease_length_o  = res_q.lease_length;
  assign renew_at_o      = res_q.renew_at;

endmodule
